>>> sv/stcfp_pkg.sv
// Shared types and constants for the serial-to-CAN frame parser.
// No dependencies; used by the top level.
package stcfp_pkg;

  // Frame buffer geometry
  localparam int unsigned FrameDepth  = 16;
  localparam int unsigned PosWidth    = 4;
  localparam int unsigned MaxPayload  = 8;

  // Byte offsets of the length byte for each layout
  localparam logic [PosWidth-1:0] StdLenIdx = 4'd3;
  localparam logic [PosWidth-1:0] ExtLenIdx = 4'd5;

  // Command code reset values
  localparam logic [7:0] StdCodeReset = 8'd1;
  localparam logic [7:0] ExtCodeReset = 8'd2;

  // Configuration register indexes
  typedef enum logic [7:0] {
    CfgStdCode = 8'd0,
    CfgExtCode = 8'd1
  } cfg_reg_e;

  // One assembled transmit request
  typedef struct packed {
    logic        is_extended;
    logic [31:0] frame_ident;
    logic [3:0]  data_length;
    logic [63:0] payload;
  } frame_t;

endpackage

>>> sv/stcfp_rx_if.sv
// Serial byte channel: valid/ready with one received byte.
// No dependencies.
interface stcfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> sv/stcfp_frame_if.sv
// Frame result channel: valid/ready with one CAN transmit request.
// No dependencies.
interface stcfp_frame_if;
  logic        valid;
  logic        ready;
  logic        is_extended;
  logic [31:0] frame_ident;
  logic [3:0]  data_length;
  logic [63:0] payload;

  modport source (output valid, output is_extended, output frame_ident,
                  output data_length, output payload, input ready);
  modport sink   (input valid, input is_extended, input frame_ident,
                  input data_length, input payload, output ready);
endinterface

>>> sv/stcfp_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
// No dependencies.
interface stcfp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/serial_to_can_frame_parser.sv
// Top level of the serial-to-CAN frame parser.
// Depends on stcfp_pkg and the stcfp_rx_if, stcfp_frame_if, stcfp_cfg_if interfaces.

// Assembles CAN transmit requests from a serial byte stream. A standard frame
// is command, id low, id high, length, data; an extended frame is command,
// four id bytes (most significant first), length, data. After the length
// byte max(length,1) bytes are taken, then one request is emitted. Unknown
// command bytes are dropped; a length above 8 drops the frame and the next
// byte is treated as a command. Each byte is registered on transfer and
// decided against the stored frame bytes, so one byte is taken per clock
// and a request is registered in the output register when its last byte is
// decided; the only stall comes from a request held in the output register
// that the sink has not taken. Configuration writes are always accepted;
// they are to be made by the user while the parser is idle; not enforced here.
module serial_to_can_frame_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  stcfp_rx_if.sink             rx_i,
  stcfp_frame_if.source        frame_o,
  stcfp_cfg_if.sink            cfg_i
);

  localparam int unsigned Pw = stcfp_pkg::PosWidth;
  localparam int unsigned Fd = stcfp_pkg::FrameDepth;

  // Configuration registers
  logic [7:0] std_code_q, ext_code_q;

  // Input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // Parser state
  logic [Pw-1:0] pos_q, pos_d;
  logic [7:0]    fb_q [Fd];

  // Result register
  logic              out_valid_q;
  stcfp_pkg::frame_t out_q;

  // Decision signals
  logic              advance;
  logic              emit;
  logic              fb_we;
  logic [Pw-1:0]     fb_waddr;
  stcfp_pkg::frame_t res;

  assign advance     = in_valid_q && (!out_valid_q || frame_o.ready);
  assign rx_i.ready  = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      std_code_q <= stcfp_pkg::StdCodeReset;
      ext_code_q <= stcfp_pkg::ExtCodeReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        stcfp_pkg::CfgStdCode: std_code_q <= cfg_i.data;
        stcfp_pkg::CfgExtCode: ext_code_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  // Per-byte decision
  always_comb begin
    logic          is_std, is_ext, cmd_hit;
    logic [Pw-1:0] len_idx;
    logic [7:0]    len;
    logic [3:0]    count;
    logic [Pw:0]   end_pos;
    logic [7:0]    fbw [Fd];
    logic [63:0]   pl;

    is_std   = (pos_q != '0) && (fb_q[0] == std_code_q);
    is_ext   = (pos_q != '0) && !is_std && (fb_q[0] == ext_code_q);
    cmd_hit  = (in_byte_q == std_code_q) || (in_byte_q == ext_code_q);
    len_idx  = is_std ? stcfp_pkg::StdLenIdx : stcfp_pkg::ExtLenIdx;
    len      = is_std ? fb_q[stcfp_pkg::StdLenIdx] : fb_q[stcfp_pkg::ExtLenIdx];
    count    = (len == 8'd0) ? 4'd1 : len[3:0];
    end_pos  = {1'b0, len_idx} + {1'b0, count};

    // buffer view including the current byte at its position
    for (int k = 0; k < Fd; k++) begin
      fbw[k] = (pos_q == Pw'(k)) ? in_byte_q : fb_q[k];
    end

    // payload bytes past the length read as zero
    pl = '0;
    for (int i = 0; i < stcfp_pkg::MaxPayload; i++) begin
      if (8'(i) < len) begin
        pl[8*i +: 8] = is_std ? fbw[4 + i] : fbw[6 + i];
      end
    end

    res.is_extended = is_ext;
    res.frame_ident = is_std ? {16'h0, fb_q[2], fb_q[1]}
                             : {fb_q[1], fb_q[2], fb_q[3], fb_q[4]};
    res.data_length = len[3:0];
    res.payload     = pl;

    emit     = 1'b0;
    fb_we    = 1'b0;
    fb_waddr = pos_q;
    pos_d    = pos_q;

    priority if (!is_std && !is_ext) begin
      // take as command byte
      fb_we    = 1'b1;
      fb_waddr = '0;
      pos_d    = cmd_hit ? Pw'(1) : '0;
    end else if (pos_q <= len_idx) begin
      // header byte
      fb_we = 1'b1;
      pos_d = pos_q + Pw'(1);
    end else if (len > 8'(stcfp_pkg::MaxPayload)) begin
      // bad length: drop frame, byte starts a new one
      fb_we    = 1'b1;
      fb_waddr = '0;
      pos_d    = cmd_hit ? Pw'(1) : '0;
    end else if ({1'b0, pos_q} < end_pos) begin
      // data byte
      fb_we = 1'b1;
      pos_d = pos_q + Pw'(1);
    end else begin
      // last byte: emit frame
      fb_we = 1'b1;
      emit  = 1'b1;
      pos_d = '0;
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (advance) begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && fb_we) begin
      fb_q[fb_waddr] <= in_byte_q;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || frame_o.ready) begin
      out_valid_q <= advance && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q <= res;
    end
  end

  assign frame_o.valid       = out_valid_q;
  assign frame_o.is_extended = out_q.is_extended;
  assign frame_o.frame_ident = out_q.frame_ident;
  assign frame_o.data_length = out_q.data_length;
  assign frame_o.payload     = out_q.payload;

endmodule
